// File: rtl/core/ckht_pkg.sv
// Package for the cuckoo hash table with stash.
// Holds sizes, entry types, command and status codes and the sequencer states.
// No dependencies.
package ckht_pkg;

  localparam int TABLE_BITS  = 10;
  localparam int STASH_DEPTH = 16;
  localparam int KEY_BITS    = 64;

  localparam int SLOT_COUNT = 1 << TABLE_BITS;
  localparam int SIDX_W     = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
  localparam int FILL_W     = $clog2(STASH_DEPTH + 1);
  localparam int CNT_W      = 11;
  localparam int ENT_W      = 192;
  localparam int SLOT_W     = ENT_W + 1;
  localparam logic [63:0] KEY_MASK = 64'((65'd1 << KEY_BITS) - 65'd1);

  typedef struct packed {
    logic [63:0] v;
    logic [31:0] h2;
    logic [31:0] h1;
    logic [63:0] k;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_ADD    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_REPLACED = 3'd0,
    ST_ADDED    = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CK1,
    S_CK2,
    S_SCK,
    S_ACT,
    S_EVCK,
    S_RSCK,
    S_DRD,
    S_DWR,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/ckht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read of the address written in the same cycle returns the new data.
// No dependencies.
module ckht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/cuckoo_hash_table_with_stash.sv
// Cuckoo hash table with overflow stash: sequencer, slot RAM and stash RAM.
// Depends on ckht_pkg and ckht_ram.
// A lookup checks both table slots, then searches the stash one entry at a time.
// An insert that evicts moves one entry at a time, up to 2^TABLE_BITS moves; a remove
// scans the stash for an entry to pull into the freed slot and compacts the stash.
// One word is in work at a time; after reset a clearing pass over every slot runs first.
module cuckoo_hash_table_with_stash
  import ckht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [63:0]       in_key,
  input  logic [31:0]       in_hash_one,
  input  logic [31:0]       in_hash_two,
  input  logic [63:0]       in_data_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [63:0]       out_read_value,
  output logic [CNT_W-1:0]  out_entry_count
);

  state_t state_r, state_nxt;

  logic [1:0]            cmd_r, cmd_nxt;
  entry_t                req_r, req_nxt;
  entry_t                cur_r, cur_nxt;
  logic                  v1_r, v1_nxt;
  logic                  hit_tab_r, hit_tab_nxt;
  logic                  hit_st_r, hit_st_nxt;
  logic [TABLE_BITS-1:0] hit_p_r, hit_p_nxt;
  logic [63:0]           hit_v_r, hit_v_nxt;
  logic [FILL_W-1:0]     idx_r, idx_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TABLE_BITS:0]   loops_r, loops_nxt;
  logic [TABLE_BITS-1:0] evp_r, evp_nxt;
  logic [TABLE_BITS:0]   clr_r, clr_nxt;
  logic [2:0]            st_r, st_nxt;
  logic [63:0]           rv_r, rv_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_status_r, out_status_nxt;
  logic [63:0]           out_rv_r, out_rv_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic                  slot_we;
  logic [TABLE_BITS-1:0] slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]     slot_wdata, slot_rdata;
  logic                  stash_we;
  logic [SIDX_W-1:0]     stash_waddr, stash_raddr;
  logic [ENT_W-1:0]      stash_wdata, stash_rdata;

  entry_t                slot_q, stash_q;
  logic                  slot_qv, slot_m, stash_m, pull_m, next_more, is_ins, out_free;
  logic [TABLE_BITS-1:0] p1, p2, evnp;
  logic [FILL_W-1:0]     idx_inc;
  logic [63:0]           new_v;

  ckht_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  ckht_ram #(.WIDTH(ENT_W), .DEPTH(STASH_DEPTH)) u_stash (
    .clk(clk), .we(stash_we), .waddr(stash_waddr), .wdata(stash_wdata),
    .raddr(stash_raddr), .rdata(stash_rdata)
  );

  assign slot_q    = entry_t'(slot_rdata[ENT_W-1:0]);
  assign slot_qv   = slot_rdata[ENT_W];
  assign stash_q   = entry_t'(stash_rdata);
  assign p1        = req_r.h1[TABLE_BITS-1:0];
  assign p2        = req_r.h2[TABLE_BITS-1:0];
  assign slot_m    = slot_qv && (slot_q.k == req_r.k) && (slot_q.h1 == req_r.h1) &&
                     (slot_q.h2 == req_r.h2);
  assign stash_m   = (stash_q.k == req_r.k) && (stash_q.h1 == req_r.h1) &&
                     (stash_q.h2 == req_r.h2);
  assign pull_m    = (stash_q.h1[TABLE_BITS-1:0] == hit_p_r) ||
                     (stash_q.h2[TABLE_BITS-1:0] == hit_p_r);
  assign idx_inc   = FILL_W'(idx_r + 1'b1);
  assign next_more = ({1'b0, idx_r} + 1'b1) < {1'b0, fill_r};
  assign evnp      = (evp_r == slot_q.h1[TABLE_BITS-1:0]) ? slot_q.h2[TABLE_BITS-1:0]
                                                          : slot_q.h1[TABLE_BITS-1:0];
  assign new_v     = (cmd_r == CMD_ADD) ? (hit_v_r + req_r.v) : req_r.v;
  assign is_ins    = (cmd_r == CMD_WRITE) || (cmd_r == CMD_ADD);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rv_r;
  assign out_entry_count = out_cnt_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == TABLE_BITS'(0) + (TABLE_BITS+1)'(SLOT_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_CK1;
      S_CK1:  state_nxt = slot_m ? S_ACT : S_CK2;
      S_CK2:  state_nxt = (slot_m || fill_r == '0) ? S_ACT : S_SCK;
      S_SCK:  state_nxt = (stash_m || !next_more) ? S_ACT : S_SCK;
      S_ACT: begin
        if (cmd_r == CMD_READ) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_REMOVE) begin
          if (hit_tab_r) state_nxt = (fill_r != '0) ? S_RSCK : S_DONE;
          else if (hit_st_r) state_nxt = S_DRD;
          else state_nxt = S_DONE;
        end else if (hit_tab_r || hit_st_r || !v1_r || !slot_qv) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_EVCK;
        end
      end
      S_EVCK: if (!slot_qv || loops_r == (TABLE_BITS+1)'(1)) state_nxt = S_DONE;
      S_RSCK: begin
        if (pull_m) state_nxt = S_DRD;
        else if (!next_more) state_nxt = S_DONE;
      end
      S_DRD:  state_nxt = next_more ? S_DWR : S_DONE;
      S_DWR:  state_nxt = S_DRD;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    cmd_nxt = cmd_r; req_nxt = req_r; cur_nxt = cur_r; v1_nxt = v1_r;
    hit_tab_nxt = hit_tab_r; hit_st_nxt = hit_st_r; hit_p_nxt = hit_p_r;
    hit_v_nxt = hit_v_r; idx_nxt = idx_r; fill_nxt = fill_r; cnt_nxt = cnt_r;
    loops_nxt = loops_r; evp_nxt = evp_r; clr_nxt = clr_r; st_nxt = st_r; rv_nxt = rv_r;
    out_status_nxt = out_status_r; out_rv_nxt = out_rv_r; out_cnt_nxt = out_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    slot_we = 1'b0; slot_waddr = p1; slot_wdata = {1'b1, req_r}; slot_raddr = p1;
    stash_we = 1'b0; stash_waddr = idx_r[SIDX_W-1:0]; stash_wdata = stash_rdata;
    stash_raddr = idx_r[SIDX_W-1:0];
    case (state_r)
      S_CLR: begin
        slot_we = 1'b1;
        slot_waddr = clr_r[TABLE_BITS-1:0];
        slot_wdata = '0;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        slot_raddr = in_hash_one[TABLE_BITS-1:0];
        if (in_valid) begin
          cmd_nxt = in_command;
          req_nxt = '{v: in_data_word, h2: in_hash_two, h1: in_hash_one,
                      k: in_key & KEY_MASK};
          hit_tab_nxt = 1'b0;
          hit_st_nxt = 1'b0;
          st_nxt = ST_MISSING;
          rv_nxt = '0;
        end
      end
      S_CK1: begin
        v1_nxt = slot_qv;
        hit_p_nxt = p1;
        hit_v_nxt = slot_q.v;
        hit_tab_nxt = slot_m;
        slot_raddr = slot_m ? p1 : p2;
      end
      S_CK2: begin
        hit_p_nxt = p2;
        hit_v_nxt = slot_q.v;
        hit_tab_nxt = slot_m;
        slot_raddr = p2;
        idx_nxt = '0;
        stash_raddr = '0;
      end
      S_SCK: begin
        slot_raddr = p2;
        hit_v_nxt = stash_q.v;
        hit_st_nxt = stash_m;
        if (!stash_m && next_more) begin
          idx_nxt = idx_inc;
          stash_raddr = idx_inc[SIDX_W-1:0];
        end
      end
      S_ACT: begin
        if (cmd_r == CMD_READ) begin
          if (hit_tab_r || hit_st_r) begin
            st_nxt = ST_FOUND;
            rv_nxt = hit_v_r;
          end
        end else if (cmd_r == CMD_REMOVE) begin
          if (hit_tab_r || hit_st_r) begin
            st_nxt = ST_REMOVED;
            if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          end
          if (hit_tab_r) begin
            slot_we = 1'b1;
            slot_waddr = hit_p_r;
            slot_wdata = '0;
            idx_nxt = '0;
            stash_raddr = '0;
          end
        end else if (hit_tab_r || hit_st_r) begin
          st_nxt = ST_REPLACED;
          rv_nxt = (cmd_r == CMD_ADD) ? new_v : '0;
          if (hit_tab_r) begin
            slot_we = 1'b1;
            slot_waddr = hit_p_r;
            slot_wdata = {1'b1, req_r.v ^ req_r.v ^ new_v, req_r.h2, req_r.h1, req_r.k};
          end else begin
            stash_we = 1'b1;
            stash_wdata = {new_v, req_r.h2, req_r.h1, req_r.k};
          end
        end else begin
          cur_nxt = req_r;
          evp_nxt = p1;
          loops_nxt = (TABLE_BITS+1)'(SLOT_COUNT);
          if (!v1_r || !slot_qv) begin
            slot_we = 1'b1;
            slot_waddr = !v1_r ? p1 : p2;
            st_nxt = ST_ADDED;
            rv_nxt = (cmd_r == CMD_ADD) ? req_r.v : '0;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_EVCK: begin
        slot_we = 1'b1;
        slot_waddr = evp_r;
        slot_wdata = {1'b1, cur_r};
        if (!slot_qv) begin
          st_nxt = ST_ADDED;
          rv_nxt = (cmd_r == CMD_ADD) ? req_r.v : '0;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cur_nxt = slot_q;
          evp_nxt = evnp;
          slot_raddr = evnp;
          loops_nxt = loops_r - 1'b1;
          if (loops_r == (TABLE_BITS+1)'(1)) begin
            if ({1'b0, fill_r} < (FILL_W+1)'(STASH_DEPTH)) begin
              stash_we = 1'b1;
              stash_waddr = fill_r[SIDX_W-1:0];
              stash_wdata = slot_q;
              fill_nxt = fill_r + 1'b1;
              st_nxt = ST_ADDED;
              rv_nxt = (cmd_r == CMD_ADD) ? req_r.v : '0;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              st_nxt = ST_FULL;
              rv_nxt = '0;
            end
          end
        end
      end
      S_RSCK: begin
        if (pull_m) begin
          slot_we = 1'b1;
          slot_waddr = hit_p_r;
          slot_wdata = {1'b1, stash_q};
        end else if (next_more) begin
          idx_nxt = idx_inc;
          stash_raddr = idx_inc[SIDX_W-1:0];
        end
      end
      S_DRD: begin
        stash_raddr = idx_inc[SIDX_W-1:0];
        if (!next_more) fill_nxt = fill_r - 1'b1;
      end
      S_DWR: begin
        stash_we = 1'b1;
        idx_nxt = idx_inc;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = st_r;
          out_rv_nxt = rv_r;
          out_cnt_nxt = cnt_r;
        end
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      fill_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      fill_r <= fill_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; req_r <= req_nxt; cur_r <= cur_nxt; v1_r <= v1_nxt;
    hit_tab_r <= hit_tab_nxt; hit_st_r <= hit_st_nxt; hit_p_r <= hit_p_nxt;
    hit_v_r <= hit_v_nxt; idx_r <= idx_nxt; loops_r <= loops_nxt; evp_r <= evp_nxt;
    st_r <= st_nxt; rv_r <= rv_nxt;
    out_status_r <= out_status_nxt; out_rv_r <= out_rv_nxt; out_cnt_r <= out_cnt_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_r} <= (FILL_W+1)'(STASH_DEPTH))
    else $error("stash fill above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1 ||
                      cnt_r == $past(cnt_r) - 1'b1))
    else $error("entry count moved by more than one");

  a_evict_loops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVCK) |-> (loops_r != '0))
    else $error("eviction chain without moves left");

  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!out_valid_r && !stash_we))
    else $error("activity during clearing pass");

endmodule

// File: bench/cuckoo_hash_table_with_stash_chk.sv
// Checker for the cuckoo hash table with stash: watches both channels, keeps its own
// copy of the table and compares every result word with the predicted one.
// Depends on ckht_pkg.
module cuckoo_hash_table_with_stash_chk
  import ckht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_command,
  input  logic [63:0]      in_key,
  input  logic [31:0]      in_hash_one,
  input  logic [31:0]      in_hash_two,
  input  logic [63:0]      in_data_word,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [2:0]       out_status,
  input  logic [63:0]      out_read_value,
  input  logic [CNT_W-1:0] out_entry_count,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    status_t          status;
    logic [63:0]      value;
    logic [CNT_W-1:0] count;
  } table_result_t;

  logic             used[SLOT_COUNT];
  entry_t           slots[SLOT_COUNT];
  entry_t           stash[STASH_DEPTH];
  int               stash_len;
  logic [CNT_W-1:0] total;
  table_result_t    result_q[$];

  function automatic logic [TABLE_BITS-1:0] slot_of(logic [31:0] h);
    return h[TABLE_BITS-1:0];
  endfunction

  function automatic logic same_key(entry_t e, logic [63:0] k, logic [31:0] h1,
                                    logic [31:0] h2);
    return e.k == k && e.h1 == h1 && e.h2 == h2;
  endfunction

  task automatic stash_remove(int idx);
    for (int j = idx; j + 1 < stash_len; j++) stash[j] = stash[j + 1];
    stash_len--;
  endtask

  task automatic table_insert(entry_t e, output logic kept);
    entry_t                cur;
    entry_t                old;
    logic [31:0]           ch;
    logic [TABLE_BITS-1:0] p;
    cur = e;
    kept = 1'b1;
    if (!used[slot_of(e.h1)]) begin
      used[slot_of(e.h1)] = 1'b1; slots[slot_of(e.h1)] = e; return;
    end
    if (!used[slot_of(e.h2)]) begin
      used[slot_of(e.h2)] = 1'b1; slots[slot_of(e.h2)] = e; return;
    end
    ch = e.h1;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      p = slot_of(ch);
      if (!used[p]) begin
        used[p] = 1'b1; slots[p] = cur; return;
      end
      old = slots[p];
      slots[p] = cur;
      cur = old;
      ch = (p == slot_of(cur.h1)) ? cur.h2 : cur.h1;
    end
    if (stash_len < STASH_DEPTH) begin
      stash[stash_len] = cur;
      stash_len++;
    end else begin
      kept = 1'b0;
    end
  endtask

  task automatic predict_word(cmd_t cmd, logic [63:0] key_in, logic [31:0] h1,
                              logic [31:0] h2, logic [63:0] d, output table_result_t r);
    logic [63:0]           k;
    logic [TABLE_BITS-1:0] p1;
    logic [TABLE_BITS-1:0] p2;
    int                    where;
    int                    sidx;
    logic                  kept;
    entry_t                e;
    k = key_in & KEY_MASK;
    p1 = slot_of(h1);
    p2 = slot_of(h2);
    r.status = ST_MISSING;
    r.value = '0;
    where = 0;
    sidx = 0;
    if (used[p1] && same_key(slots[p1], k, h1, h2)) where = 1;
    else if (used[p2] && same_key(slots[p2], k, h1, h2)) where = 2;
    else begin
      for (int i = 0; i < stash_len; i++) begin
        if (where == 0 && same_key(stash[i], k, h1, h2)) begin
          where = 3; sidx = i;
        end
      end
    end
    case (cmd)
      CMD_WRITE, CMD_ADD: begin
        if (where != 0) begin
          if (where == 3) begin
            stash[sidx].v = (cmd == CMD_WRITE) ? d : stash[sidx].v + d;
            r.value = stash[sidx].v;
          end else begin
            e = (where == 1) ? slots[p1] : slots[p2];
            e.v = (cmd == CMD_WRITE) ? d : e.v + d;
            if (where == 1) slots[p1] = e; else slots[p2] = e;
            r.value = e.v;
          end
          if (cmd == CMD_WRITE) r.value = '0;
          r.status = ST_REPLACED;
        end else begin
          e.k = k; e.h1 = h1; e.h2 = h2; e.v = d;
          table_insert(e, kept);
          if (kept) begin
            total++;
            r.status = ST_ADDED;
            r.value = (cmd == CMD_ADD) ? d : '0;
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      CMD_READ: begin
        if (where != 0) begin
          r.status = ST_FOUND;
          r.value = (where == 1) ? slots[p1].v : (where == 2) ? slots[p2].v : stash[sidx].v;
        end
      end
      default: begin
        if (where != 0) begin
          r.status = ST_REMOVED;
          if (total != 0) total--;
          if (where == 3) begin
            stash_remove(sidx);
          end else begin
            p1 = (where == 1) ? p1 : p2;
            used[p1] = 1'b0;
            for (int i = 0; i < stash_len; i++) begin
              if (!used[p1] && (slot_of(stash[i].h1) == p1 || slot_of(stash[i].h2) == p1))
              begin
                used[p1] = 1'b1;
                slots[p1] = stash[i];
                stash_remove(i);
              end
            end
          end
        end
      end
    endcase
    r.count = total;
  endtask

  always @(posedge clk) begin
    table_result_t r;
    int            errs;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) used[i] = 1'b0;
      stash_len = 0;
      total = '0;
      result_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      errs = 0;
      if (in_valid && !in_stall) begin
        predict_word(cmd_t'(in_command), in_key, in_hash_one, in_hash_two, in_data_word, r);
        result_q.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result word with no expectation waiting");
          errs++;
        end else begin
          r = result_q.pop_front();
          if (out_status !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, out_status);
            errs++;
          end
          if (out_read_value !== r.value) begin
            $error("read_value: expected %h, actual %h", r.value, out_read_value);
            errs++;
          end
          if (out_entry_count !== r.count) begin
            $error("entry_count: expected %0d, actual %0d", r.count, out_entry_count);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= result_q.size();
    end
  end

endmodule

// File: bench/cuckoo_hash_table_with_stash_tb.sv
// Testbench top for the cuckoo hash table with stash: drives directed and random words,
// random idling on both sides, and gives the verdict from the checker's failure count.
// Depends on ckht_pkg, cuckoo_hash_table_with_stash and cuckoo_hash_table_with_stash_chk.
module cuckoo_hash_table_with_stash_tb;
  import ckht_pkg::*;

  localparam int IDLE_LIMIT = 60000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_command = CMD_READ;
  logic [63:0]      in_key = '0;
  logic [31:0]      in_hash_one = '0;
  logic [31:0]      in_hash_two = '0;
  logic [63:0]      in_data_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_status;
  logic [63:0]      out_read_value;
  logic [CNT_W-1:0] out_entry_count;
  int               fail_count;
  int               pending;
  int               idle_cycles = 0;
  logic             hold_off = 1'b0;
  logic             no_gaps = 1'b0;
  logic [63:0]      pool_key[64];
  logic [31:0]      pool_h1[64];
  logic [31:0]      pool_h2[64];

  always #5 clk = ~clk;

  cuckoo_hash_table_with_stash u_top (.*);

  cuckoo_hash_table_with_stash_chk u_chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(cmd_t cmd, logic [63:0] k, logic [31:0] h1, logic [31:0] h2,
                           logic [63:0] d);
    int g;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= k;
    in_hash_one <= h1;
    in_hash_two <= h2;
    in_data_word <= d;
    do @(posedge clk); while (in_stall);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] hash_at(int slot);
    return {(32 - TABLE_BITS)'($urandom_range(0, (1 << (32 - TABLE_BITS)) - 1)),
            slot[TABLE_BITS-1:0]};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always begin
    @(posedge clk);
    if (hold_off) begin
      out_stall <= 1'b1;
      repeat (400) @(posedge clk);
      hold_off = 1'b0;
    end else if (no_gaps) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (gap_len() > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[cuckoo_hash_table_with_stash] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    int base;
    int span;
    int idx;
    int items;
    int r;
    cmd_t cmd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_word(CMD_WRITE, 64'h0, 32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(CMD_WRITE, '1, '1, 32'h0000_0001, 64'h0);
    send_word(CMD_READ, 64'h0, 32'h0, 32'hFFFF_FFFF, 64'h0);
    send_word(CMD_ADD, 64'h0, 32'h0, 32'hFFFF_FFFF, 64'h1);
    send_word(CMD_ADD, 64'h55, 32'h0000_0123, 32'h0000_0321, 64'h8000_0000_0000_0000);
    send_word(CMD_WRITE, '1, '1, 32'h0000_0001, 64'h1234);
    send_word(CMD_READ, 64'h77, 32'h0000_0123, 32'h0000_0321, 64'h0);
    send_word(CMD_REMOVE, 64'h77, 32'h0000_0123, 32'h0000_0321, 64'h0);
    send_word(CMD_REMOVE, 64'h0, 32'h0, 32'hFFFF_FFFF, 64'h0);
    for (int i = 0; i < 19; i++) begin
      pool_key[i] = 64'h100 + i;
      pool_h1[i] = hash_at(5);
      pool_h2[i] = hash_at(6);
      send_word(CMD_WRITE, pool_key[i], pool_h1[i], pool_h2[i], rand64());
    end
    send_word(CMD_REMOVE, pool_key[0], pool_h1[0], pool_h2[0], 64'h0);
    send_word(CMD_REMOVE, pool_key[10], pool_h1[10], pool_h2[10], 64'h0);
    send_word(CMD_READ, pool_key[12], pool_h1[12], pool_h2[12], 64'h0);

    for (int ph = 0; ph < 7; ph++) begin
      span = (ph == 2) ? 3 : (ph == 5) ? SLOT_COUNT : $urandom_range(8, 40);
      n = (ph == 2) ? 30 : (ph == 5) ? 64 : $urandom_range(16, 64);
      items = (ph == 2) ? 120 : 280;
      base = $urandom_range(0, SLOT_COUNT - 1);
      no_gaps = (ph == 4);
      for (int i = 0; i < n; i++) begin
        pool_key[i] = rand64();
        pool_h1[i] = hash_at(base + $urandom_range(0, span - 1));
        pool_h2[i] = hash_at(base + $urandom_range(0, span - 1));
      end
      if (ph == 3) hold_off = 1'b1;
      for (int i = 0; i < items; i++) begin
        cmd = cmd_t'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        idx = $urandom_range(0, n - 1);
        if (r < 85) send_word(cmd, pool_key[idx], pool_h1[idx], pool_h2[idx], rand64());
        else send_word(cmd, rand64(), $urandom, $urandom, rand64());
      end
      if (ph == 1) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[cuckoo_hash_table_with_stash] OK");
    end else begin
      $display("[cuckoo_hash_table_with_stash] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ckht_pkg.sv
rtl/core/ckht_ram.sv
rtl/core/cuckoo_hash_table_with_stash.sv
bench/cuckoo_hash_table_with_stash_chk.sv
bench/cuckoo_hash_table_with_stash_tb.sv
